FILE: hdl/xorshift_rng_with_range_core_macros.svh
`ifndef XORSHIFT_RNG_WITH_RANGE_CORE_MACROS_SVH
`define XORSHIFT_RNG_WITH_RANGE_CORE_MACROS_SVH

// check outside reset
`define XRNG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check at every edge, reset included
`define XRNG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hdl/xrng_pkg.sv
`timescale 1ns / 1ps

package xrng_pkg;

   localparam int XRNG_W = 64;
   localparam int HALF_W = XRNG_W / 2;
   localparam int FRAC_W = 53;
   localparam int EXP_W  = 11;

   localparam logic [XRNG_W-1:0] MUL_CONST       = 64'h2545F4914F6CDD1D;
   localparam logic [XRNG_W-1:0] ZERO_SEED_CONST = 64'h9E3779B97F4A7C15;
   localparam logic [XRNG_W-1:0] RESET_STATE     = 64'h2545F4914F6CDD1D;
   localparam logic [EXP_W-1:0]  EXP_TOP         = 11'd1022;

   typedef enum logic [1:0] {
      OP_SEED  = 2'd0,
      OP_FRAC  = 2'd1,
      OP_RANGE = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_SEL,
      S_NORM,
      S_DIV,
      S_OUT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [XRNG_W-1:0] dividend;
      logic [XRNG_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [XRNG_W-1:0] remainder;
   } div_rsp_type;

   function automatic logic [XRNG_W-1:0] xorshift(input logic [XRNG_W-1:0] s);
      logic [XRNG_W-1:0] x;
      x = s ^ (s >> 12);
      x = x ^ (x << 25);
      x = x ^ (x >> 27);
      return x;
   endfunction

endpackage

FILE: hdl/xrng_div.sv
`timescale 1ns / 1ps

module xrng_div (
   input  logic                 clock,
   input  logic                 reset,
   input  xrng_pkg::div_req_type req,
   output xrng_pkg::div_rsp_type rsp
);

   localparam int CNT_W = $clog2(xrng_pkg::XRNG_W);

   logic [xrng_pkg::XRNG_W-1:0] quo_ff, quo_in;
   logic [xrng_pkg::XRNG_W-1:0] rem_ff, rem_in;
   logic [xrng_pkg::XRNG_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        run_ff, run_in;
   logic                        done_ff, done_in;

   logic [xrng_pkg::XRNG_W:0]   shifted;
   logic [xrng_pkg::XRNG_W:0]   diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[xrng_pkg::XRNG_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in = req.dividend;
         rem_in = '0;
         dvs_in = req.divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[xrng_pkg::XRNG_W-2:0], ~diff[xrng_pkg::XRNG_W]};
         rem_in = diff[xrng_pkg::XRNG_W] ? shifted[xrng_pkg::XRNG_W-1:0]
                                         : diff[xrng_pkg::XRNG_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (&cnt_ff) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.remainder = rem_ff;

endmodule

FILE: hdl/xorshift_rng_with_range_core.sv
`timescale 1ns / 1ps
// channel | ports           | tdata (low bit up)              | tuser
// request | req_t*          | operand_a, operand_b (128 bits) | opcode [1:0]
// result  | rsp_t*          | value_bits (64 bits)            | status [0]
//
// Seed, unused opcode and reversed bounds: S_IDLE goes straight to S_OUT, which raises rsp_tvalid once rsp is free.
// Fraction: S_MUL uses the 32x32 multiplier three times, then S_SEL and, unless
// the mantissa is zero, a one-bit-per-cycle normalize shift in S_NORM. Range:
// S_MUL, then the 64-step restoring divider; a full-range span skips the divider.
// One item at a time; the next item is taken while a result waits on rsp.
// Synchronous active-high reset loads the generator state and empties rsp.
`include "xorshift_rng_with_range_core_macros.svh"

module xorshift_rng_with_range_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // operand_a [63:0], operand_b [127:64]
   input  logic [1:0]   req_tuser,   // opcode [1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // value_bits [63:0]
   output logic [0:0]   rsp_tuser    // status [0]
);

   localparam int W  = xrng_pkg::XRNG_W;
   localparam int HW = xrng_pkg::HALF_W;
   localparam int FW = xrng_pkg::FRAC_W;
   localparam int EW = xrng_pkg::EXP_W;

   xrng_pkg::state_type state_ff, state_in;
   xrng_pkg::op_type    op_ff, op_in;
   logic [W-1:0]        gen_ff, gen_in;
   logic [W-1:0]        lo_ff, lo_in;
   logic [W-1:0]        span_ff, span_in;
   logic [W-1:0]        acc_ff, acc_in;
   logic [1:0]          mcnt_ff, mcnt_in;
   logic [FW-1:0]       mant_ff, mant_in;
   logic [EW-1:0]       exp_ff, exp_in;
   logic [W-1:0]        res_ff, res_in;
   logic                stat_ff, stat_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]        rsp_data_ff, rsp_data_in;
   logic                rsp_stat_ff, rsp_stat_in;

   logic [W-1:0]        req_a, req_b;
   xrng_pkg::op_type    req_op;
   logic                req_fire;
   logic                bad_bounds;
   logic [HW-1:0]       mul_a, mul_b;
   logic [W-1:0]        mul_p;
   xrng_pkg::div_req_type div_req;
   xrng_pkg::div_rsp_type div_rsp;

   assign req_a      = req_tdata[W-1:0];
   assign req_b      = req_tdata[2*W-1:W];
   assign req_op     = xrng_pkg::op_type'(req_tuser);
   assign req_fire   = req_tvalid && req_tready;
   assign bad_bounds = $signed(req_a) > $signed(req_b);

   xrng_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      unique case (mcnt_ff)
         2'd0: begin
            mul_a = gen_ff[HW-1:0];
            mul_b = xrng_pkg::MUL_CONST[HW-1:0];
         end
         2'd1: begin
            mul_a = gen_ff[HW-1:0];
            mul_b = xrng_pkg::MUL_CONST[W-1:HW];
         end
         default: begin
            mul_a = gen_ff[W-1:HW];
            mul_b = xrng_pkg::MUL_CONST[HW-1:0];
         end
      endcase
      mul_p = W'(mul_a) * W'(mul_b);
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      gen_in       = gen_ff;
      lo_in        = lo_ff;
      span_in      = span_ff;
      acc_in       = acc_ff;
      mcnt_in      = mcnt_ff;
      mant_in      = mant_ff;
      exp_in       = exp_ff;
      res_in       = res_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_stat_in  = rsp_stat_ff;
      req_tready   = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = acc_ff;
      div_req.divisor  = span_ff;

      unique case (state_ff)
         xrng_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in   = req_op;
               lo_in   = req_a;
               span_in = req_b - req_a + 1'b1;
               res_in  = '0;
               stat_in = 1'b0;
               mcnt_in = '0;
               state_in = xrng_pkg::S_OUT;
               unique case (req_op)
                  xrng_pkg::OP_SEED: begin
                     gen_in = (req_a == '0) ? xrng_pkg::ZERO_SEED_CONST : req_a;
                  end
                  xrng_pkg::OP_FRAC: begin
                     gen_in   = xrng_pkg::xorshift(gen_ff);
                     state_in = xrng_pkg::S_MUL;
                  end
                  xrng_pkg::OP_RANGE: begin
                     if (bad_bounds) begin
                        stat_in = 1'b1;
                     end else begin
                        gen_in   = xrng_pkg::xorshift(gen_ff);
                        state_in = xrng_pkg::S_MUL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         xrng_pkg::S_MUL: begin
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == 2'd0) begin
               acc_in = mul_p;
            end else begin
               acc_in = {acc_ff[W-1:HW] + mul_p[HW-1:0], acc_ff[HW-1:0]};
            end
            if (mcnt_ff == 2'd2) begin
               state_in = xrng_pkg::S_SEL;
            end
         end
         xrng_pkg::S_SEL: begin
            if (op_ff == xrng_pkg::OP_FRAC) begin
               mant_in = acc_ff[W-1:W-FW];
               exp_in  = xrng_pkg::EXP_TOP;
               if (acc_ff[W-1:W-FW] == '0) begin
                  state_in = xrng_pkg::S_OUT;
               end else begin
                  state_in = xrng_pkg::S_NORM;
               end
            end else if (span_ff == '0) begin
               res_in   = acc_ff;
               state_in = xrng_pkg::S_OUT;
            end else begin
               div_req.start = 1'b1;
               state_in      = xrng_pkg::S_DIV;
            end
         end
         xrng_pkg::S_NORM: begin
            if (mant_ff[FW-1]) begin
               res_in   = {1'b0, exp_ff, mant_ff[FW-2:0]};
               state_in = xrng_pkg::S_OUT;
            end else begin
               mant_in = {mant_ff[FW-2:0], 1'b0};
               exp_in  = exp_ff - 1'b1;
            end
         end
         xrng_pkg::S_DIV: begin
            if (div_rsp.done) begin
               res_in   = lo_ff + div_rsp.remainder;
               state_in = xrng_pkg::S_OUT;
            end
         end
         xrng_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_stat_in  = stat_ff;
               state_in     = xrng_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = xrng_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= xrng_pkg::S_IDLE;
         gen_ff       <= xrng_pkg::RESET_STATE;
         mcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         mcnt_ff      <= mcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      lo_ff       <= lo_in;
      span_ff     <= span_in;
      acc_ff      <= acc_in;
      mant_ff     <= mant_in;
      exp_ff      <= exp_in;
      res_ff      <= res_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_stat_ff;

   `XRNG_ASSERT(a_one_at_a_time, req_fire |=> !req_tready, "accepted a beat while busy")
   `XRNG_ASSERT(a_bad_bounds_hold, (req_fire && req_op == xrng_pkg::OP_RANGE && bad_bounds) |=> $stable(gen_ff), "state moved on reversed bounds")
   `XRNG_ASSERT(a_err_zero, (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == '0), "error beat carries nonzero value")
   `XRNG_ASSERT_ALWAYS(a_reset_state, reset |=> (gen_ff == xrng_pkg::RESET_STATE && !rsp_tvalid), "reset state wrong")

endmodule

FILE: dv/xorshift_rng_with_range_core_tb.sv
`timescale 1ns / 1ps

module xorshift_rng_with_range_core_tb;

   typedef struct packed {
      xrng_pkg::op_type op;
      logic [63:0]      a;
      logic [63:0]      b;
   } rng_cmd_type;

   typedef struct packed {
      logic [63:0] value;
      logic        status;
   } rng_draw_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata  = '0;   // operand_a [63:0], operand_b [127:64]
   logic [1:0]   req_tuser  = '0;   // opcode [1:0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;         // value_bits [63:0]
   logic [0:0]   rsp_tuser;         // status [0]

   rng_cmd_type  cmd_q[$];
   rng_draw_type draw_q[$];
   rng_cmd_type  cur_cmd   = '0;
   logic [63:0]  gen_state = xrng_pkg::RESET_STATE;
   int           errors    = 0;
   int           idle_cycles = 0;
   int           gap_left  = 0;
   int           burst_left = 0;
   int           stall_mode = 0;
   int           mode_left = 0;

   xorshift_rng_with_range_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [63:0] rng_advance();
      logic [63:0] x;
      x = gen_state;
      x = x ^ (x >> 12);
      x = x ^ (x << 25);
      x = x ^ (x >> 27);
      gen_state = x;
      return x * xrng_pkg::MUL_CONST;
   endfunction

   function automatic logic [63:0] double_bits(input logic [52:0] m);
      int          k;
      logic [63:0] mm;
      if (m == '0) return 64'd0;
      k = 52;
      while (!m[k]) k--;
      mm = {11'd0, m} << (52 - k);
      return {1'b0, 11'(970 + k), mm[51:0]};
   endfunction

   function automatic rng_draw_type compute_draw(input rng_cmd_type c);
      rng_draw_type d;
      logic [63:0]  span;
      logic [63:0]  r;
      d.value  = 64'd0;
      d.status = 1'b0;
      case (c.op)
         xrng_pkg::OP_SEED: gen_state = (c.a == 64'd0) ? xrng_pkg::ZERO_SEED_CONST : c.a;
         xrng_pkg::OP_FRAC: begin
            r = rng_advance();
            d.value = double_bits(r[63:11]);
         end
         xrng_pkg::OP_RANGE: begin
            if ($signed(c.a) > $signed(c.b)) begin
               d.status = 1'b1;
            end else begin
               span = c.b - c.a + 64'd1;
               r = rng_advance();
               d.value = (span == 64'd0) ? r : c.a + (r % span);
            end
         end
         default: ;
      endcase
      return d;
   endfunction

   // seed whose next draw yields product p
   function automatic logic [63:0] seed_for_output(input logic [63:0] p);
      logic [63:0] inv;
      logic [63:0] x;
      inv = xrng_pkg::MUL_CONST;
      repeat (6) inv = inv * (64'd2 - xrng_pkg::MUL_CONST * inv);
      x = inv * p;
      x = x ^ (x >> 27) ^ (x >> 54);
      x = x ^ (x << 25) ^ (x << 50);
      x = x ^ (x >> 12) ^ (x >> 24) ^ (x >> 36) ^ (x >> 48) ^ (x >> 60);
      return x;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic push_cmd(input xrng_pkg::op_type op, input logic [63:0] a,
                           input logic [63:0] b);
      rng_cmd_type c;
      c.op = op;
      c.a  = a;
      c.b  = b;
      cmd_q.push_back(c);
   endtask

   always @(posedge clock) begin : drive
      logic busy;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            draw_q.push_back(compute_draw(cur_cmd));
            busy = 1'b0;
         end
         if (!busy) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (cmd_q.size() > 0) begin
               cur_cmd = cmd_q.pop_front();
               busy = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
               end
            end
         end
         req_tvalid <= busy;
         req_tdata  <= {cur_cmd.b, cur_cmd.a};
         req_tuser  <= cur_cmd.op;
      end
   end

   always @(posedge clock) begin : stall
      logic rdy;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 400);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rdy = 1'b1;
            1: rdy = ($urandom_range(0, 3) != 0);
            2: rdy = ($urandom_range(0, 3) == 0);
            default: rdy = ($urandom_range(0, 7) == 0);
         endcase
         rsp_tready <= rdy;
      end
   end

   always @(posedge clock) begin : monitor
      rng_draw_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (draw_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat value %h status %0d", $time, rsp_tdata, rsp_tuser);
         end else begin
            want = draw_q.pop_front();
            if (rsp_tdata !== want.value) begin
               errors++;
               $display("%0t: value expected %h actual %h", $time, want.value, rsp_tdata);
            end
            if (rsp_tuser[0] !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= 5000) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [63:0] a;
      logic [63:0] b;
      int          sel;
      int          n;

      push_cmd(xrng_pkg::OP_SEED, 64'd0, 64'd0);
      push_cmd(xrng_pkg::OP_FRAC, '1, '1);
      push_cmd(xrng_pkg::OP_RANGE, 64'd0, 64'd0);
      push_cmd(xrng_pkg::OP_SEED, {1'b0, {63{1'b1}}}, 64'd0);
      push_cmd(xrng_pkg::OP_FRAC, 64'd0, 64'd0);
      push_cmd(xrng_pkg::OP_RANGE, {1'b1, 63'd0}, {1'b0, {63{1'b1}}});
      push_cmd(xrng_pkg::OP_RANGE, {1'b0, {63{1'b1}}}, {1'b1, 63'd0});
      push_cmd(xrng_pkg::OP_RANGE, {1'b0, {63{1'b1}}}, {1'b0, {63{1'b1}}});
      push_cmd(xrng_pkg::OP_RANGE, {1'b1, 63'd0}, {1'b1, 63'd0});
      push_cmd(xrng_pkg::OP_NONE, rand64(), rand64());
      push_cmd(xrng_pkg::OP_SEED, seed_for_output(64'd3), 64'd0);
      push_cmd(xrng_pkg::OP_FRAC, 64'd0, 64'd0);
      push_cmd(xrng_pkg::OP_SEED, seed_for_output(64'd1 << 11), 64'd0);
      push_cmd(xrng_pkg::OP_FRAC, 64'd0, 64'd0);
      push_cmd(xrng_pkg::OP_SEED, seed_for_output('1), 64'd0);
      push_cmd(xrng_pkg::OP_FRAC, 64'd0, 64'd0);
      push_cmd(xrng_pkg::OP_SEED, {1'b1, 63'd0}, 64'd0);
      push_cmd(xrng_pkg::OP_RANGE, '1, 64'd0);
      push_cmd(xrng_pkg::OP_RANGE, {1'b1, 63'd0}, '1);
      push_cmd(xrng_pkg::OP_RANGE, 64'd0, {1'b0, {63{1'b1}}});
      push_cmd(xrng_pkg::OP_RANGE, 64'd1, 64'd0);
      push_cmd(xrng_pkg::OP_SEED, seed_for_output('1), 64'd0);
      push_cmd(xrng_pkg::OP_RANGE, 64'd0, {1'b0, {63{1'b1}}});
      push_cmd(xrng_pkg::OP_FRAC, 64'd0, 64'd0);

      for (int i = 0; i < 900; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            a = ($urandom_range(0, 7) == 0) ? 64'd0 : rand64();
            push_cmd(xrng_pkg::OP_SEED, a, rand64());
         end else if (sel < 40) begin
            push_cmd(xrng_pkg::OP_FRAC, rand64(), rand64());
         end else if (sel < 95) begin
            a = rand64();
            case ($urandom_range(0, 7))
               0: b = rand64();
               1: b = a + 64'($urandom_range(0, 100));
               2: begin
                  a = 64'($urandom_range(0, 200)) - 64'd100;
                  b = a + 64'($urandom_range(0, 50));
               end
               3: begin
                  n = $urandom_range(1, 63);
                  b = a + ((64'd1 << n) - 64'd1);
               end
               4: begin
                  a = {1'b1, 63'd0} + 64'($urandom_range(0, 3));
                  b = {1'b0, {63{1'b1}}} - 64'($urandom_range(0, 3));
               end
               5: begin
                  a = -{32'd0, $urandom};
                  b = {32'd0, $urandom};
               end
               6: b = a;
               default: b = a - 64'($urandom_range(1, 1000));
            endcase
            push_cmd(xrng_pkg::OP_RANGE, a, b);
         end else begin
            push_cmd(xrng_pkg::OP_NONE, rand64(), rand64());
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (cmd_q.size() != 0 || req_tvalid || draw_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/xrng_pkg.sv
hdl/xrng_div.sv
hdl/xorshift_rng_with_range_core.sv
dv/xorshift_rng_with_range_core_tb.sv
